>>> rtl/core/smsq_pkg.sv
// Shared types, constants and sequencer codes for the subarray minimum sum query block.
`default_nettype none
package smsq_pkg;

   localparam int DEPTH_DEF      = 4096;
   localparam int LEVELS_DEF     = 13;
   localparam int VALUE_BITS_DEF = 32;

   localparam int VALUE_W = 32;
   localparam int POS_W   = 13;
   localparam int ANS_W   = 64;

   localparam logic FUNC_LOAD  = 1'b0;
   localparam logic FUNC_QUERY = 1'b1;

   typedef enum logic [5:0] {
      OP_IDLE,
      OP_L0,
      OP_LCHK,
      OP_LRA,
      OP_LRB,
      OP_LEA,
      OP_LEB,
      OP_LW,
      OP_SE,
      OP_SV,
      OP_ST,
      OP_STI,
      OP_STC,
      OP_SPUSH,
      OP_RA,
      OP_RB,
      OP_RC,
      OP_RD,
      OP_RE,
      OP_RF,
      OP_LA,
      OP_LB,
      OP_LC,
      OP_LD,
      OP_LE,
      OP_LF,
      OP_Q_LEN,
      OP_Q_TA,
      OP_Q_TB,
      OP_Q_EA,
      OP_Q_EB,
      OP_Q_SEL,
      OP_Q_RD0,
      OP_Q_RD1,
      OP_Q_DIF,
      OP_Q_SUM,
      OP_Q_SUB3,
      OP_Q_SUB4,
      OP_Q_ADD2,
      OP_DONE
   } op_type;

   typedef struct packed {
      op_type op;
      logic   accept;
      logic   load_rsp;
   } cmd_type;

   typedef struct packed {
      logic q_bad;
      logic last_i;
      logic first_i;
      logic stk_empty;
      logic pop;
      logic lvl_go;
      logic lvl_end;
   } status_type;

endpackage
`default_nettype wire

>>> rtl/core/smsq_ram.sv
// Generic single write port, single read port RAM with registered read data.
`default_nettype none
module smsq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule
`default_nettype wire

>>> rtl/core/smsq_ctrl.sv
// Sequencer that steps the datapath through loading, preprocessing and queries.
`default_nettype none
module smsq_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire logic                   req_func,
   input  wire logic                   req_value_last,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   input  wire smsq_pkg::status_type   status,
   output smsq_pkg::cmd_type           cmd
);

   smsq_pkg::op_type state_ff, state_in;
   logic             rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= smsq_pkg::OP_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      cmd.op       = state_ff;
      cmd.accept   = 1'b0;
      cmd.load_rsp = 1'b0;
      req_ready    = 1'b0;
      case (state_ff)
         smsq_pkg::OP_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               if (req_func == smsq_pkg::FUNC_LOAD) begin
                  if (req_value_last) begin
                     state_in = smsq_pkg::OP_L0;
                  end
               end else if (status.q_bad) begin
                  state_in = smsq_pkg::OP_DONE;
               end else begin
                  state_in = smsq_pkg::OP_Q_LEN;
               end
            end
         end
         smsq_pkg::OP_L0: begin
            if (status.last_i) begin
               state_in = smsq_pkg::OP_LCHK;
            end
         end
         smsq_pkg::OP_LCHK: begin
            state_in = status.lvl_go ? smsq_pkg::OP_LRA : smsq_pkg::OP_SE;
         end
         smsq_pkg::OP_LRA: state_in = smsq_pkg::OP_LRB;
         smsq_pkg::OP_LRB: state_in = smsq_pkg::OP_LEA;
         smsq_pkg::OP_LEA: state_in = smsq_pkg::OP_LEB;
         smsq_pkg::OP_LEB: state_in = smsq_pkg::OP_LW;
         smsq_pkg::OP_LW: begin
            state_in = status.lvl_end ? smsq_pkg::OP_LCHK : smsq_pkg::OP_LRA;
         end
         smsq_pkg::OP_SE: state_in = smsq_pkg::OP_SV;
         smsq_pkg::OP_SV: state_in = smsq_pkg::OP_ST;
         smsq_pkg::OP_ST: begin
            state_in = status.stk_empty ? smsq_pkg::OP_SPUSH : smsq_pkg::OP_STI;
         end
         smsq_pkg::OP_STI: state_in = smsq_pkg::OP_STC;
         smsq_pkg::OP_STC: begin
            state_in = status.pop ? smsq_pkg::OP_ST : smsq_pkg::OP_SPUSH;
         end
         smsq_pkg::OP_SPUSH: begin
            state_in = status.last_i ? smsq_pkg::OP_RA : smsq_pkg::OP_SE;
         end
         smsq_pkg::OP_RA: state_in = smsq_pkg::OP_RB;
         smsq_pkg::OP_RB: state_in = smsq_pkg::OP_RC;
         smsq_pkg::OP_RC: state_in = smsq_pkg::OP_RD;
         smsq_pkg::OP_RD: state_in = smsq_pkg::OP_RE;
         smsq_pkg::OP_RE: state_in = smsq_pkg::OP_RF;
         smsq_pkg::OP_RF: begin
            state_in = status.last_i ? smsq_pkg::OP_LA : smsq_pkg::OP_RA;
         end
         smsq_pkg::OP_LA: state_in = smsq_pkg::OP_LB;
         smsq_pkg::OP_LB: state_in = smsq_pkg::OP_LC;
         smsq_pkg::OP_LC: state_in = smsq_pkg::OP_LD;
         smsq_pkg::OP_LD: state_in = smsq_pkg::OP_LE;
         smsq_pkg::OP_LE: state_in = smsq_pkg::OP_LF;
         smsq_pkg::OP_LF: begin
            state_in = status.first_i ? smsq_pkg::OP_IDLE : smsq_pkg::OP_LA;
         end
         smsq_pkg::OP_Q_LEN:  state_in = smsq_pkg::OP_Q_TA;
         smsq_pkg::OP_Q_TA:   state_in = smsq_pkg::OP_Q_TB;
         smsq_pkg::OP_Q_TB:   state_in = smsq_pkg::OP_Q_EA;
         smsq_pkg::OP_Q_EA:   state_in = smsq_pkg::OP_Q_EB;
         smsq_pkg::OP_Q_EB:   state_in = smsq_pkg::OP_Q_SEL;
         smsq_pkg::OP_Q_SEL:  state_in = smsq_pkg::OP_Q_RD0;
         smsq_pkg::OP_Q_RD0:  state_in = smsq_pkg::OP_Q_RD1;
         smsq_pkg::OP_Q_RD1:  state_in = smsq_pkg::OP_Q_DIF;
         smsq_pkg::OP_Q_DIF:  state_in = smsq_pkg::OP_Q_SUM;
         smsq_pkg::OP_Q_SUM:  state_in = smsq_pkg::OP_Q_SUB3;
         smsq_pkg::OP_Q_SUB3: state_in = smsq_pkg::OP_Q_SUB4;
         smsq_pkg::OP_Q_SUB4: state_in = smsq_pkg::OP_Q_ADD2;
         smsq_pkg::OP_Q_ADD2: state_in = smsq_pkg::OP_DONE;
         smsq_pkg::OP_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_rsp = 1'b1;
               state_in     = smsq_pkg::OP_IDLE;
            end
         end
         default: state_in = smsq_pkg::OP_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule
`default_nettype wire

>>> rtl/core/smsq_dp.sv
// Datapath: element, table, stack, chain and prefix memories, the multiplier and registers.
`default_nettype none
module smsq_dp #(
   parameter int DEPTH      = smsq_pkg::DEPTH_DEF,
   parameter int LEVELS     = smsq_pkg::LEVELS_DEF,
   parameter int VALUE_BITS = smsq_pkg::VALUE_BITS_DEF
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire smsq_pkg::cmd_type                  cmd,
   output smsq_pkg::status_type                    status,
   input  wire logic                               req_func,
   input  wire logic [smsq_pkg::VALUE_W-1:0]       req_value,
   input  wire logic [smsq_pkg::POS_W-1:0]         req_left_pos,
   input  wire logic [smsq_pkg::POS_W-1:0]         req_right_pos,
   output logic      [smsq_pkg::ANS_W-1:0]         rsp_answer,
   output logic                                    rsp_range_error
);

   localparam int PW   = $clog2(DEPTH + 2);
   localparam int MD   = 2 ** PW;
   localparam int KLW  = $clog2(LEVELS);
   localparam int KW   = $clog2(LEVELS + 1);
   localparam int TAW  = KLW + PW;
   localparam int VB   = VALUE_BITS;
   localparam int AW   = smsq_pkg::ANS_W;
   localparam int CW   = (PW > smsq_pkg::POS_W) ? PW : smsq_pkg::POS_W;
   localparam int MSW  = $clog2(PW);
   localparam int PLW  = 32 + PW;

   // Control and index registers.
   logic [PW-1:0]  cnt_ff, cnt_in, i_ff, i_in, top_ff, top_in;
   logic [PW-1:0]  ra_ff, ra_in, rb_ff, rb_in, l_ff, l_in, r_ff, r_in;
   logic           ready_ff, ready_in, err_ff, err_in;
   logic [KW-1:0]  k_ff, k_in;
   logic [KLW-1:0] kq_ff, kq_in;
   logic [PW:0]    pow_ff, pow_in;
   logic signed [VB-1:0] va_ff, va_in, vb_ff, vb_in;
   logic [AW-1:0]  acc_ff, acc_in, t0_ff, t0_in, t1_ff, t1_in, c0_ff, c0_in, c1_ff, c1_in;
   logic [AW-1:0]  ans_ff, ans_in;
   logic           rerr_ff, rerr_in;

   // Multiplier pipeline: 64-bit operand times a position difference, in two halves.
   logic [AW-1:0]  mx_ff, mx_in;
   logic [PW-1:0]  mf_ff, mf_in;
   logic [PLW-1:0] plo_ff, plo_in;
   logic [31:0]    phi_ff, phi_in;
   logic [AW-1:0]  prod_ff, prod_in;

   // Memory ports.
   logic           el_we;
   logic [PW-1:0]  el_waddr, el_raddr;
   logic [VB-1:0]  el_wdata, el_rdata;
   logic           tab_we;
   logic [TAW-1:0] tab_waddr, tab_raddr;
   logic [PW-1:0]  tab_wdata, tab_rdata;
   logic           stk_we;
   logic [PW-1:0]  stk_waddr, stk_raddr, stk_wdata, stk_rdata;
   logic           lsp_we;
   logic [PW-1:0]  lsp_waddr, lsp_raddr, lsp_wdata, lsp_rdata;
   logic           rsp_we;
   logic [PW-1:0]  rsp_waddr, rsp_raddr, rsp_wdata, rsp_rdata;
   logic           rch_we, lch_we, rpre_we, lpre_we;
   logic [PW-1:0]  rch_waddr, rch_raddr, lch_waddr, lch_raddr;
   logic [PW-1:0]  rpre_waddr, rpre_raddr, lpre_waddr, lpre_raddr;
   logic [AW-1:0]  rch_wdata, rch_rdata, lch_wdata, lch_rdata;
   logic [AW-1:0]  rpre_wdata, rpre_rdata, lpre_wdata, lpre_rdata;

   logic signed [VB-1:0] elem_rd;
   logic [PW-1:0]  n1, base, len;
   logic           room;
   logic [KW-1:0]  km1;
   logic [MSW-1:0] msb;
   logic [KLW-1:0] kcap;

   smsq_ram #(.WIDTH(VB), .DEPTH(MD)) u_elem (
      .clock(clock), .we(el_we), .waddr(el_waddr), .wdata(el_wdata),
      .raddr(el_raddr), .rdata(el_rdata));
   smsq_ram #(.WIDTH(PW), .DEPTH(2 ** TAW)) u_tab (
      .clock(clock), .we(tab_we), .waddr(tab_waddr), .wdata(tab_wdata),
      .raddr(tab_raddr), .rdata(tab_rdata));
   smsq_ram #(.WIDTH(PW), .DEPTH(MD)) u_stk (
      .clock(clock), .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
      .raddr(stk_raddr), .rdata(stk_rdata));
   smsq_ram #(.WIDTH(PW), .DEPTH(MD)) u_lsp (
      .clock(clock), .we(lsp_we), .waddr(lsp_waddr), .wdata(lsp_wdata),
      .raddr(lsp_raddr), .rdata(lsp_rdata));
   smsq_ram #(.WIDTH(PW), .DEPTH(MD)) u_rsp (
      .clock(clock), .we(rsp_we), .waddr(rsp_waddr), .wdata(rsp_wdata),
      .raddr(rsp_raddr), .rdata(rsp_rdata));
   smsq_ram #(.WIDTH(AW), .DEPTH(MD)) u_rch (
      .clock(clock), .we(rch_we), .waddr(rch_waddr), .wdata(rch_wdata),
      .raddr(rch_raddr), .rdata(rch_rdata));
   smsq_ram #(.WIDTH(AW), .DEPTH(MD)) u_lch (
      .clock(clock), .we(lch_we), .waddr(lch_waddr), .wdata(lch_wdata),
      .raddr(lch_raddr), .rdata(lch_rdata));
   smsq_ram #(.WIDTH(AW), .DEPTH(MD)) u_rpre (
      .clock(clock), .we(rpre_we), .waddr(rpre_waddr), .wdata(rpre_wdata),
      .raddr(rpre_raddr), .rdata(rpre_rdata));
   smsq_ram #(.WIDTH(AW), .DEPTH(MD)) u_lpre (
      .clock(clock), .we(lpre_we), .waddr(lpre_waddr), .wdata(lpre_wdata),
      .raddr(lpre_raddr), .rdata(lpre_rdata));

   assign elem_rd = $signed(el_rdata);
   assign n1      = cnt_ff + PW'(1);
   assign base    = ready_ff ? '0 : cnt_ff;
   assign room    = base < PW'(DEPTH);
   assign km1     = k_ff - KW'(1);
   assign len     = r_ff - l_ff + PW'(1);

   always_comb begin
      msb = '0;
      for (int b = 0; b < PW; b++) begin
         if (len[b]) begin
            msb = MSW'(b);
         end
      end
   end

   assign kcap = (int'(msb) > LEVELS - 1) ? KLW'(LEVELS - 1) : KLW'(msb);

   assign status.q_bad = !ready_ff || (req_left_pos == '0) ||
                         (req_left_pos > req_right_pos) ||
                         (CW'(req_right_pos) > CW'(cnt_ff));
   assign status.last_i    = i_ff == cnt_ff;
   assign status.first_i   = i_ff == PW'(1);
   assign status.stk_empty = top_ff == '0;
   assign status.pop       = vb_ff < elem_rd;
   assign status.lvl_go    = (k_ff < KW'(LEVELS)) && (pow_ff <= {1'b0, cnt_ff});
   assign status.lvl_end   = ({1'b0, i_ff} + pow_ff - (PW + 1)'(1)) == {1'b0, cnt_ff};

   assign plo_in  = PLW'(mx_ff[31:0]) * PLW'(mf_ff);
   assign phi_in  = mx_ff[63:32] * 32'(mf_ff);
   assign prod_in = AW'(plo_ff) + {phi_ff, 32'b0};

   always_comb begin
      cnt_in = cnt_ff;  i_in = i_ff;    top_in = top_ff;  ra_in = ra_ff;  rb_in = rb_ff;
      l_in = l_ff;      r_in = r_ff;    ready_in = ready_ff;  err_in = err_ff;
      k_in = k_ff;      kq_in = kq_ff;  pow_in = pow_ff;  va_in = va_ff;  vb_in = vb_ff;
      acc_in = acc_ff;  t0_in = t0_ff;  t1_in = t1_ff;    c0_in = c0_ff;  c1_in = c1_ff;
      mx_in = mx_ff;    mf_in = mf_ff;
      ans_in = ans_ff;  rerr_in = rerr_ff;

      el_we = 1'b0;   el_waddr = base + PW'(1);  el_wdata = req_value[VB-1:0];  el_raddr = i_ff;
      tab_we = 1'b0;  tab_waddr = {k_ff[KLW-1:0], i_ff};  tab_wdata = i_ff;
      tab_raddr = {km1[KLW-1:0], i_ff};
      stk_we = 1'b0;  stk_waddr = top_ff;  stk_wdata = i_ff;  stk_raddr = top_ff - PW'(1);
      lsp_we = 1'b0;  lsp_waddr = i_ff;  lsp_wdata = status.stk_empty ? '0 : ra_ff;
      lsp_raddr = i_ff;
      rsp_we = 1'b0;  rsp_waddr = i_ff;  rsp_wdata = n1;  rsp_raddr = i_ff;
      rch_we = 1'b0;  rch_waddr = i_ff;  rch_wdata = prod_ff + c0_ff;  rch_raddr = ra_ff;
      lch_we = 1'b0;  lch_waddr = i_ff;  lch_wdata = prod_ff + c0_ff;  lch_raddr = ra_ff;
      rpre_we = 1'b0; rpre_waddr = i_ff; rpre_wdata = acc_ff + c0_ff; rpre_raddr = ra_ff;
      lpre_we = 1'b0; lpre_waddr = i_ff; lpre_wdata = acc_ff + c0_ff; lpre_raddr = ra_ff;

      case (cmd.op)
         smsq_pkg::OP_IDLE: begin
            if (cmd.accept) begin
               i_in = PW'(1);
               if (req_func == smsq_pkg::FUNC_LOAD) begin
                  ready_in = 1'b0;
                  cnt_in   = base;
                  if (room) begin
                     cnt_in = base + PW'(1);
                     el_we  = 1'b1;
                  end
               end else begin
                  l_in   = PW'(req_left_pos);
                  r_in   = PW'(req_right_pos);
                  err_in = status.q_bad;
               end
            end
         end
         smsq_pkg::OP_L0: begin
            tab_we    = 1'b1;
            tab_waddr = {KLW'(0), i_ff};
            if (status.last_i) begin
               k_in   = KW'(1);
               pow_in = (PW + 1)'(2);
            end else begin
               i_in = i_ff + PW'(1);
            end
         end
         smsq_pkg::OP_LCHK: begin
            i_in   = PW'(1);
            top_in = '0;
         end
         smsq_pkg::OP_LRA: ;
         smsq_pkg::OP_LRB: begin
            ra_in     = tab_rdata;
            tab_raddr = {km1[KLW-1:0], PW'({1'b0, i_ff} + (pow_ff >> 1))};
         end
         smsq_pkg::OP_LEA: begin
            rb_in    = tab_rdata;
            el_raddr = ra_ff;
         end
         smsq_pkg::OP_LEB: begin
            va_in    = elem_rd;
            el_raddr = rb_ff;
         end
         smsq_pkg::OP_LW: begin
            tab_we    = 1'b1;
            tab_wdata = (elem_rd < va_ff) ? rb_ff : ra_ff;
            if (status.lvl_end) begin
               k_in   = k_ff + KW'(1);
               pow_in = pow_ff << 1;
               i_in   = PW'(1);
            end else begin
               i_in = i_ff + PW'(1);
            end
         end
         smsq_pkg::OP_SE: rsp_we = 1'b1;
         smsq_pkg::OP_SV: vb_in = elem_rd;
         smsq_pkg::OP_ST: ;
         smsq_pkg::OP_STI: begin
            ra_in    = stk_rdata;
            el_raddr = stk_rdata;
         end
         smsq_pkg::OP_STC: begin
            if (status.pop) begin
               rsp_we    = 1'b1;
               rsp_waddr = ra_ff;
               rsp_wdata = i_ff;
               top_in    = top_ff - PW'(1);
            end
         end
         smsq_pkg::OP_SPUSH: begin
            lsp_we = 1'b1;
            stk_we = 1'b1;
            top_in = top_ff + PW'(1);
            if (status.last_i) begin
               i_in   = PW'(1);
               acc_in = '0;
            end else begin
               i_in = i_ff + PW'(1);
            end
         end
         smsq_pkg::OP_RA: ;
         smsq_pkg::OP_RB: begin
            ra_in     = lsp_rdata;
            mx_in     = AW'(elem_rd);
            mf_in     = i_ff - lsp_rdata;
            rch_raddr = lsp_rdata;
         end
         smsq_pkg::OP_RC: c0_in = (ra_ff == '0) ? '0 : rch_rdata;
         smsq_pkg::OP_RD: ;
         smsq_pkg::OP_RE: begin
            c0_in  = prod_ff + c0_ff;
            rch_we = 1'b1;
         end
         smsq_pkg::OP_RF: begin
            rpre_we = 1'b1;
            acc_in  = acc_ff + c0_ff;
            if (status.last_i) begin
               i_in   = cnt_ff;
               acc_in = '0;
            end else begin
               i_in = i_ff + PW'(1);
            end
         end
         smsq_pkg::OP_LA: ;
         smsq_pkg::OP_LB: begin
            ra_in     = rsp_rdata;
            mx_in     = AW'(elem_rd);
            mf_in     = rsp_rdata - i_ff;
            lch_raddr = rsp_rdata;
         end
         smsq_pkg::OP_LC: c0_in = (ra_ff == n1) ? '0 : lch_rdata;
         smsq_pkg::OP_LD: ;
         smsq_pkg::OP_LE: begin
            c0_in  = prod_ff + c0_ff;
            lch_we = 1'b1;
         end
         smsq_pkg::OP_LF: begin
            lpre_we = 1'b1;
            acc_in  = acc_ff + c0_ff;
            if (status.first_i) begin
               ready_in = 1'b1;
            end else begin
               i_in = i_ff - PW'(1);
            end
         end
         smsq_pkg::OP_Q_LEN: kq_in = kcap;
         smsq_pkg::OP_Q_TA: tab_raddr = {kq_ff, l_ff};
         smsq_pkg::OP_Q_TB: begin
            ra_in     = tab_rdata;
            tab_raddr = {kq_ff, r_ff - (PW'(1) << kq_ff) + PW'(1)};
         end
         smsq_pkg::OP_Q_EA: begin
            rb_in    = tab_rdata;
            el_raddr = ra_ff;
         end
         smsq_pkg::OP_Q_EB: begin
            va_in    = elem_rd;
            el_raddr = rb_ff;
         end
         smsq_pkg::OP_Q_SEL: begin
            if (elem_rd < va_ff) begin
               ra_in = rb_ff;
               va_in = elem_rd;
            end
         end
         smsq_pkg::OP_Q_RD0: begin
            mx_in      = AW'(va_ff);
            mf_in      = ra_ff - l_ff + PW'(1);
            rpre_raddr = r_ff;
            lpre_raddr = l_ff;
         end
         smsq_pkg::OP_Q_RD1: begin
            t0_in = rpre_rdata;
            t1_in = lpre_rdata;
            c1_in = lch_rdata;
            mx_in = rch_rdata;
            mf_in = r_ff - ra_ff;
         end
         smsq_pkg::OP_Q_DIF: begin
            t0_in = t0_ff - rpre_rdata;
            t1_in = t1_ff - lpre_rdata;
            mx_in = c1_ff;
            mf_in = ra_ff - l_ff;
         end
         smsq_pkg::OP_Q_SUM: begin
            acc_in = t0_ff + t1_ff;
            mx_in  = prod_ff;
            mf_in  = r_ff - ra_ff + PW'(1);
         end
         smsq_pkg::OP_Q_SUB3: acc_in = acc_ff - prod_ff;
         smsq_pkg::OP_Q_SUB4: acc_in = acc_ff - prod_ff;
         smsq_pkg::OP_Q_ADD2: acc_in = acc_ff + prod_ff;
         smsq_pkg::OP_DONE: begin
            if (cmd.load_rsp) begin
               ans_in  = err_ff ? '0 : acc_ff;
               rerr_in = err_ff;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff   <= '0;
         ready_ff <= 1'b0;
      end else begin
         cnt_ff   <= cnt_in;
         ready_ff <= ready_in;
      end
   end

   always_ff @(posedge clock) begin
      i_ff <= i_in;    top_ff <= top_in;  ra_ff <= ra_in;  rb_ff <= rb_in;
      l_ff <= l_in;    r_ff <= r_in;      err_ff <= err_in;
      k_ff <= k_in;    kq_ff <= kq_in;    pow_ff <= pow_in;
      va_ff <= va_in;  vb_ff <= vb_in;
      acc_ff <= acc_in;  t0_ff <= t0_in;  t1_ff <= t1_in;  c0_ff <= c0_in;  c1_ff <= c1_in;
      mx_ff <= mx_in;  mf_ff <= mf_in;  plo_ff <= plo_in;  phi_ff <= phi_in;
      prod_ff <= prod_in;
      ans_ff <= ans_in;  rerr_ff <= rerr_in;
   end

   assign rsp_answer      = ans_ff;
   assign rsp_range_error = rerr_ff;

endmodule
`default_nettype wire

>>> rtl/core/subarray_min_sum_query_top.sv
// Top level of the subarray minimum sum query block: sequencer plus datapath.
`default_nettype none
// Load words append signed values to the sequence, one per cycle; the load word marked last
// starts preprocessing, during which no word is accepted. Preprocessing writes level zero of
// the range-minimum table, then every further level entry by entry, each entry reading two
// table entries and their elements through the one table read port and one element read
// port, then runs the nearest-smaller stack pass with its pushes and pops, then the right
// and left chain and prefix-sum passes, paced by the three-stage shared multiplier. A query
// word is answered after the two table reads, the element reads and four products through
// that multiplier. An invalid query, or one issued before preprocessing ends, answers zero
// with the error flag set. The result sits in an output register, so a new word is accepted
// while the previous result is still waiting to be taken. A load word after a finished
// sequence starts a new sequence.
module subarray_min_sum_query_top #(
   parameter int DEPTH      = smsq_pkg::DEPTH_DEF,
   parameter int LEVELS     = smsq_pkg::LEVELS_DEF,
   parameter int VALUE_BITS = smsq_pkg::VALUE_BITS_DEF
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_ready,
   input  wire logic                         req_func,
   input  wire logic [smsq_pkg::VALUE_W-1:0] req_value,
   input  wire logic                         req_value_last,
   input  wire logic [smsq_pkg::POS_W-1:0]   req_left_pos,
   input  wire logic [smsq_pkg::POS_W-1:0]   req_right_pos,
   output logic                              rsp_valid,
   input  wire logic                         rsp_ready,
   output logic [smsq_pkg::ANS_W-1:0]        rsp_answer,
   output logic                              rsp_range_error
);

   smsq_pkg::cmd_type    cmd;
   smsq_pkg::status_type status;

   // The sequencer owns both handshakes; the datapath only follows its commands.
   smsq_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_func       (req_func),
      .req_value_last (req_value_last),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .status         (status),
      .cmd            (cmd)
   );

   smsq_dp #(
      .DEPTH      (DEPTH),
      .LEVELS     (LEVELS),
      .VALUE_BITS (VALUE_BITS)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_func        (req_func),
      .req_value       (req_value),
      .req_left_pos    (req_left_pos),
      .req_right_pos   (req_right_pos),
      .rsp_answer      (rsp_answer),
      .rsp_range_error (rsp_range_error)
   );

endmodule
`default_nettype wire
